>>> hw/rtl/sine_taylor_series_core_defines.svh
// assertion macros shared by the sine core checker
`ifndef SINE_TAYLOR_SERIES_CORE_DEFINES_SVH
`define SINE_TAYLOR_SERIES_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define STS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sts_pkg.sv
// types, constants and tables for the fixed-point taylor sine core
package sts_pkg;

	localparam int MAX_TERMS = 16;

	// port field widths
	localparam int ANGLE_W = 32;
	localparam int SINE_W  = 32;
	localparam int RED_W   = 31;
	localparam int TERMS_W = 5;
	localparam int THR_W   = 31;

	localparam int S_TDATA_W   = ANGLE_W;
	localparam int M_FIELDS_W  = SINE_W + RED_W + TERMS_W;
	localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int SINE_LSB    = 0;
	localparam int RED_LSB     = SINE_LSB + SINE_W;
	localparam int TERMS_LSB   = RED_LSB + RED_W;

	// internal datapath widths
	localparam int FRAC     = 28;                // fraction bits of the angle and x^2
	localparam int X_W      = ANGLE_W + 4;       // Q7.24 scaled to Q7.28
	localparam int AX_W     = 30;                // |x| after folding, at most pi
	localparam int X2_W     = 32;
	localparam int M_W      = 33;                // term magnitude, Q.30
	localparam int SUM_W    = 36;
	localparam int MUL_W    = 32;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int DIVD_W   = PROD_W - FRAC;
	localparam int DIV_BITS = 4;
	localparam int DIV_CYC  = DIVD_W / DIV_BITS;
	localparam int DCNT_W   = $clog2(DIV_CYC);

	localparam int CNT_W   = $clog2(MAX_TERMS + 1);
	localparam int IDX_W   = $clog2(MAX_TERMS);
	localparam int DEN_MAX = 2 * (MAX_TERMS - 1) * (2 * (MAX_TERMS - 1) + 1);
	localparam int DEN_W   = $clog2(DEN_MAX + 1);
	localparam int TERMS_MAX_OUT = (MAX_TERMS > 31) ? 31 : MAX_TERMS;

	localparam logic signed [X_W-1:0]    PI_Q28     = X_W'(843314857);
	localparam logic signed [X_W-1:0]    TWO_PI_Q28 = X_W'(1686629713);
	localparam logic signed [SUM_W-1:0]  ONE_Q30    = SUM_W'(1073741824);
	localparam logic signed [SINE_W-1:0] SINE_LIMIT = SINE_W'(1073741824);
	localparam logic signed [RED_W-1:0]  RED_LIMIT  = RED_W'(843314857);
	localparam logic [THR_W-1:0]         THR_RESET  = THR_W'(1074);

	// 2k(2k+1) for term k
	typedef logic [DEN_W-1:0] den_tab_t [MAX_TERMS];

	function automatic den_tab_t build_den();
		den_tab_t t;
		for (int k = 0; k < MAX_TERMS; k++) begin
			t[k] = DEN_W'(2 * k * (2 * k + 1));
		end
		return t;
	endfunction

	localparam den_tab_t DEN_TABLE = build_den();

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_TEST,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIVIDE,
		ST_ACCUM,
		ST_FINISH
	} state_t;

endpackage

>>> hw/rtl/sine_taylor_series_core.sv
// taylor series sine core with 2*pi range folding, one shared multiplier and a radix-16 divider
// the angle is folded by 2*pi up to 20 times, then T terms are summed (T = 1..MAX_TERMS); each
// extra term takes compare, multiply, top-bit add of the product, divider passes of 4 quotient
// bits each, and accumulate; one item at a time: s_tready is high only while idle, so a new
// transfer waits until the result is loaded, and longer while an earlier result stalls;
// reset clears sequencer and output valid, threshold 1074
module sine_taylor_series_core
	import sts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // angle_in
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // sine_value, reduced_angle, terms_used, zero pad
	output logic                 m_tuser,   // term_limit_hit
	input  logic                 cfg_we,
	input  logic [THR_W-1:0]     cfg_wdata
);

	state_t state_q, state_d;

	logic signed [X_W-1:0]   x_q;
	logic [AX_W-1:0]         ax_q;
	logic [X2_W-1:0]         x2_q;
	logic [M_W-1:0]          m_q;
	logic                    neg_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        count_q;
	logic                    limit_q;
	logic [PROD_W-1:0]       prod_q;
	logic [DEN_W-1:0]        den_q;
	logic [DIVD_W-1:0]       quo_q;
	logic [DEN_W-1:0]        rem_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic [THR_W-1:0]        thr_q;

	logic                    out_valid_q;
	logic [M_TDATA_W-1:0]    out_data_q;
	logic                    out_user_q;

	logic                    x_lt, x_gt;
	logic signed [X_W-1:0]   x_abs;
	logic [MUL_W-1:0]        mul_a, mul_b;
	logic [PROD_W-1:0]       mul_p;
	logic [PROD_W-1:0]       prod_sum;
	logic [DEN_W-1:0]        rem_nx;
	logic [DIVD_W-1:0]       quo_nx;
	logic [M_W-1:0]          m_init;
	logic signed [SUM_W-1:0] init_ext, term_ext;
	logic signed [SUM_W-1:0] sum_sat;
	logic [31:0]             cnt_ext;
	logic [TERMS_W-1:0]      terms_out;
	logic                    more_terms, at_limit, div_last;
	logic                    out_load;

	// fold and magnitude
	assign x_lt  = x_q < -PI_Q28;
	assign x_gt  = x_q > PI_Q28;
	assign x_abs = x_q[X_W-1] ? -x_q : x_q;

	// shared multiplier: |x|^2 once, then m * x2 for every term
	assign mul_a = (state_q == ST_SQUARE) ? MUL_W'(ax_q) : m_q[MUL_W-1:0];
	assign mul_b = (state_q == ST_SQUARE) ? MUL_W'(ax_q) : x2_q;
	assign mul_p = mul_a * mul_b;

	// top bit of m adds x2 shifted up; the full product stays below 2^64
	assign prod_sum = prod_q + (m_q[M_W-1] ? {x2_q, {(M_W-1){1'b0}}} : '0);

	// restoring division, DIV_BITS quotient bits a cycle
	always_comb begin
		logic [DEN_W:0]    r;
		logic [DIVD_W-1:0] qv;
		r  = {1'b0, rem_q};
		qv = quo_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			r  = {r[DEN_W-1:0], qv[DIVD_W-1]};
			qv = {qv[DIVD_W-2:0], 1'b0};
			if (r >= {1'b0, den_q}) begin
				r     = r - {1'b0, den_q};
				qv[0] = 1'b1;
			end
		end
		rem_nx = r[DEN_W-1:0];
		quo_nx = qv;
	end

	assign m_init   = {1'b0, ax_q, 2'b00};
	assign init_ext = signed'({{(SUM_W-M_W){1'b0}}, m_init});
	assign term_ext = signed'({{(SUM_W-M_W){1'b0}}, quo_q[M_W-1:0]});

	assign more_terms = m_q > M_W'(thr_q);
	assign at_limit   = count_q >= CNT_W'(MAX_TERMS);
	assign div_last   = dcnt_q == DCNT_W'(DIV_CYC - 1);

	// result formatting
	always_comb begin
		if (sum_q > ONE_Q30) begin
			sum_sat = ONE_Q30;
		end else if (sum_q < -ONE_Q30) begin
			sum_sat = -ONE_Q30;
		end else begin
			sum_sat = sum_q;
		end
	end

	assign cnt_ext   = 32'(count_q);
	assign terms_out = (cnt_ext > 32'd31) ? TERMS_W'(31) : cnt_ext[TERMS_W-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (!x_lt && !x_gt) begin
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: state_d = ST_TEST;
			ST_TEST: begin
				if (!more_terms || at_limit) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_MUL_LO;
				end
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (div_last) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: state_d = ST_TEST;
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= {s_tdata, 4'b0000};
			end
			ST_REDUCE: begin
				if (x_lt) begin
					x_q <= x_q + TWO_PI_Q28;
				end else if (x_gt) begin
					x_q <= x_q - TWO_PI_Q28;
				end else begin
					ax_q <= x_abs[AX_W-1:0];
				end
			end
			ST_SQUARE: begin
				x2_q    <= mul_p[FRAC +: X2_W];
				m_q     <= m_init;
				neg_q   <= x_q[X_W-1];
				sum_q   <= x_q[X_W-1] ? -init_ext : init_ext;
				count_q <= CNT_W'(1);
				limit_q <= 1'b0;
			end
			ST_TEST: begin
				if (more_terms && at_limit) begin
					limit_q <= 1'b1;
				end
			end
			ST_MUL_LO: begin
				prod_q <= mul_p;
				den_q  <= DEN_TABLE[count_q[IDX_W-1:0]];
			end
			ST_MUL_HI: begin
				quo_q  <= prod_sum[PROD_W-1:FRAC];
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			ST_DIVIDE: begin
				quo_q  <= quo_nx;
				rem_q  <= rem_nx;
				dcnt_q <= dcnt_q + DCNT_W'(1);
			end
			ST_ACCUM: begin
				// quotient is known to fit the term width
				m_q     <= quo_q[M_W-1:0];
				neg_q   <= !neg_q;
				sum_q   <= neg_q ? sum_q + term_ext : sum_q - term_ext;
				count_q <= count_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {{(M_TDATA_W-M_FIELDS_W){1'b0}}, terms_out,
			               x_q[RED_W-1:0], sum_sat[SINE_W-1:0]};
			out_user_q <= limit_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

>>> hw/rtl/sts_checker.sv
// port-level checks for the taylor sine core, bound to the top level
`include "sine_taylor_series_core_defines.svh"

module sts_checker
	import sts_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser
);

	logic signed [SINE_W-1:0] sine_f;
	logic signed [RED_W-1:0]  red_f;
	logic [TERMS_W-1:0]       terms_f;

	assign sine_f  = m_tdata[SINE_LSB +: SINE_W];
	assign red_f   = m_tdata[RED_LSB +: RED_W];
	assign terms_f = m_tdata[TERMS_LSB +: TERMS_W];

	// a stalled result holds
	`STS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// one angle in flight at a time
	`STS_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "input taken while busy")

	// sine saturated, angle folded into [-pi, pi]
	`STS_ASSERT_NOW(a_ranges, m_tvalid, (sine_f <= SINE_LIMIT) && (sine_f >= -SINE_LIMIT) && (red_f <= RED_LIMIT) && (red_f >= -RED_LIMIT), "result field out of range")

	// term count sane, and the limit flag only with the full count
	`STS_ASSERT_NOW(a_terms, m_tvalid, (terms_f != '0) && (!m_tuser || (terms_f == TERMS_W'(TERMS_MAX_OUT))), "bad term count")

endmodule

bind sine_taylor_series_core sts_checker u_sts_checker (.*);
